### sv/multi_pattern_censor_engine_core_macros.svh
// Assertion macros shared by the censor engine RTL.
`ifndef MULTI_PATTERN_CENSOR_ENGINE_CORE_MACROS_SVH
`define MULTI_PATTERN_CENSOR_ENGINE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define MPCE_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define MPCE_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define MPCE_ASSERT_IMPL(label, clk, rst_n, prop)
`define MPCE_NEVER(label, clk, rst_n, expr)
`endif
`endif

### sv/mpce_pkg.sv
`default_nettype none
package mpce_pkg;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned SYM_W = 5;
    localparam int unsigned IDX_W = 12;
    localparam int unsigned LEN_W = 13;
    localparam logic [LEN_W-1:0] DEPTH_MAX = 13'd8191;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_END    = 3'd1,
        CMD_BUILD  = 3'd2,
        CMD_TEXT   = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5,
        CMD_NOP6   = 3'd6,
        CMD_NOP7   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NODEFULL = 2'd1,
        ST_STKFULL  = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] stack_depth;
        logic [LEN_W-1:0] removed_length;
        logic [SYM_W-1:0] read_symbol;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_INS_RD, S_INS_WAIT, S_INS_DO, S_END_RD, S_END_DO,
        S_TXT_RD, S_TXT_LEN, S_TXT_LWAIT, S_TXT_DO, S_TXT_POP, S_TXT_POPW,
        S_TXT_POPDO, S_RD_RD, S_RD_WAIT, S_B_ROOT, S_B_ROOTW, S_B_ROOTDO,
        S_B_DEQ, S_B_DEQW, S_B_FAIL, S_B_CRD, S_B_CWAIT, S_B_CDO, S_B_DONE,
        S_OUT
    } t_state;

    // controller -> datapath commands
    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_INS_RD, OP_INS_DO, OP_END_RD, OP_END_DO,
        OP_TXT_RD, OP_TXT_LEN, OP_TXT_DO, OP_TXT_POP, OP_TXT_POPDO,
        OP_RD_RD, OP_RD_DO, OP_B_INIT, OP_B_ROOTRD, OP_B_ROOTDO, OP_B_DEQ,
        OP_B_FAILRD, OP_B_FAIL, OP_B_CRD, OP_B_CWAIT, OP_B_CDO, OP_B_DONE,
        OP_CLEAR, OP_SET_BAD, OP_SET_NODEFULL, OP_SET_STKFULL
    } t_op;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             built;
        logic             sym_ok;
        logic             stk_full;
        logic             node_full;
        logic             child_zero;
        logic             len_zero;
        logic             sp_zero;
        logic             idx_ok;
        logic             queue_empty;
        logic             last_sym;
    } t_status_bus;
endpackage
`default_nettype wire

### sv/mpce_ram.sv
`default_nettype none
module mpce_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/mpce_ctrl.sv
`default_nettype none
module mpce_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_clr_done,
    input  wire mpce_pkg::t_status_bus i_st,
    output mpce_pkg::t_op             o_op
);
    import mpce_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_clr_done) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (t_cmd'(i_st.cmd))
                    CMD_INSERT: n_state = (i_st.built || !i_st.sym_ok) ? S_OUT : S_INS_RD;
                    CMD_END:    n_state = i_st.built ? S_OUT : S_END_RD;
                    CMD_BUILD:  n_state = i_st.built ? S_OUT : S_B_ROOT;
                    CMD_TEXT: begin
                        if (!i_st.built || !i_st.sym_ok || i_st.stk_full) n_state = S_OUT;
                        else n_state = S_TXT_RD;
                    end
                    CMD_READ:   n_state = i_st.idx_ok ? S_RD_RD : S_OUT;
                    default:    n_state = S_OUT;
                endcase
            end
            S_INS_RD:    n_state = S_INS_WAIT;
            S_INS_WAIT:  n_state = S_INS_DO;
            S_INS_DO:    n_state = S_OUT;
            S_END_RD:    n_state = S_END_DO;
            S_END_DO:    n_state = S_OUT;
            S_TXT_RD:    n_state = S_TXT_LEN;
            S_TXT_LEN:   n_state = S_TXT_LWAIT;
            S_TXT_LWAIT: n_state = S_TXT_DO;
            S_TXT_DO:    n_state = i_st.len_zero ? S_OUT : S_TXT_POP;
            S_TXT_POP:   n_state = i_st.sp_zero ? S_OUT : S_TXT_POPW;
            S_TXT_POPW:  n_state = S_TXT_POPDO;
            S_TXT_POPDO: n_state = S_OUT;
            S_RD_RD:     n_state = S_RD_WAIT;
            S_RD_WAIT:   n_state = S_OUT;
            S_B_ROOT:    n_state = S_B_ROOTW;
            S_B_ROOTW:   n_state = S_B_ROOTDO;
            S_B_ROOTDO:  n_state = i_st.last_sym ? S_B_DEQ : S_B_ROOT;
            S_B_DEQ:     n_state = i_st.queue_empty ? S_B_DONE : S_B_DEQW;
            S_B_DEQW:    n_state = S_B_FAIL;
            S_B_FAIL:    n_state = S_B_CRD;
            S_B_CRD:     n_state = S_B_CWAIT;
            S_B_CWAIT:   n_state = S_B_CDO;
            S_B_CDO:     n_state = i_st.last_sym ? S_B_DEQ : S_B_CRD;
            S_B_DONE:    n_state = S_OUT;
            S_OUT:       n_state = i_out_stall ? S_OUT : S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op        = OP_NONE;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_clr_done;
                if (i_in_valid && i_clr_done) o_op = OP_LATCH;
            end
            S_DECODE: begin
                case (t_cmd'(i_st.cmd))
                    CMD_INSERT: o_op = (i_st.built || !i_st.sym_ok) ? OP_SET_BAD : OP_NONE;
                    CMD_END:    o_op = i_st.built ? OP_SET_BAD : OP_NONE;
                    CMD_BUILD:  o_op = i_st.built ? OP_SET_BAD : OP_B_INIT;
                    CMD_TEXT: begin
                        if (!i_st.built || !i_st.sym_ok) o_op = OP_SET_BAD;
                        else if (i_st.stk_full) o_op = OP_SET_STKFULL;
                    end
                    CMD_READ:   o_op = i_st.idx_ok ? OP_NONE : OP_SET_BAD;
                    CMD_CLEAR:  o_op = OP_CLEAR;
                    default:    o_op = OP_NONE;
                endcase
            end
            S_INS_RD:    o_op = OP_INS_RD;
            S_INS_DO:    o_op = (i_st.child_zero && i_st.node_full) ? OP_SET_NODEFULL
                                                                    : OP_INS_DO;
            S_END_RD:    o_op = OP_END_RD;
            S_END_DO:    o_op = OP_END_DO;
            S_TXT_RD:    o_op = OP_TXT_RD;
            S_TXT_LEN:   o_op = OP_TXT_LEN;
            S_TXT_DO:    o_op = OP_TXT_DO;
            S_TXT_POP:   o_op = OP_TXT_POP;
            S_TXT_POPDO: o_op = OP_TXT_POPDO;
            S_RD_RD:     o_op = OP_RD_RD;
            S_RD_WAIT:   o_op = OP_RD_DO;
            S_B_ROOT:    o_op = OP_B_ROOTRD;
            S_B_ROOTW:   o_op = OP_B_ROOTRD;
            S_B_ROOTDO:  o_op = OP_B_ROOTDO;
            S_B_DEQ:     o_op = i_st.queue_empty ? OP_NONE : OP_B_DEQ;
            S_B_DEQW:    o_op = OP_B_FAILRD;
            S_B_FAIL:    o_op = OP_B_FAIL;
            S_B_CRD:     o_op = OP_B_CRD;
            S_B_CWAIT:   o_op = OP_B_CWAIT;
            S_B_CDO:     o_op = OP_B_CDO;
            S_B_DONE:    o_op = OP_B_DONE;
            S_OUT:       o_out_valid = 1'b1;
            default:     o_op = OP_NONE;
        endcase
    end

`include "multi_pattern_censor_engine_core_macros.svh"
    `MPCE_NEVER(a_accept_only_idle, i_clk, i_rst_n, (!o_in_stall && r_state != S_IDLE))
    `MPCE_NEVER(a_out_only_in_out, i_clk, i_rst_n, (o_out_valid && r_state != S_OUT))
    `MPCE_ASSERT_IMPL(a_out_holds, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> o_out_valid)
endmodule
`default_nettype wire

### sv/mpce_datapath.sv
`default_nettype none
module mpce_datapath #(
    parameter int unsigned NODE_COUNT  = 1024,
    parameter int unsigned ALPHABET    = 26,
    parameter int unsigned STACK_DEPTH = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mpce_pkg::t_in_item     i_item,
    input  wire mpce_pkg::t_op          i_op,
    output mpce_pkg::t_status_bus       o_st,
    output logic                        o_clr_done,
    output mpce_pkg::t_out_item         o_item
);
    import mpce_pkg::*;

    localparam int unsigned NW  = $clog2(NODE_COUNT);
    localparam int unsigned AW  = $clog2(ALPHABET);
    localparam int unsigned GD  = NODE_COUNT * ALPHABET;
    localparam int unsigned GW  = $clog2(GD);
    localparam int unsigned SW  = $clog2(STACK_DEPTH);
    localparam int unsigned SPW = SW + 1;
    localparam int unsigned NCW = NW + 1;

    // item registers
    logic [CMD_W-1:0] r_cmd;
    logic [SYM_W-1:0] r_sym;
    logic [IDX_W-1:0] r_idx;
    logic [1:0]       r_status;
    logic [LEN_W-1:0] r_removed;
    logic [SYM_W-1:0] r_rsym;

    // control state
    logic             r_built;
    logic [NCW-1:0]   r_node_count;
    logic [NW-1:0]    r_cursor;
    logic [LEN_W-1:0] r_ins_depth;
    logic [SPW-1:0]   r_sp;
    logic [NW-1:0]    r_mstate;
    logic [NCW-1:0]   r_head, r_tail;
    logic [AW-1:0]    r_c;
    logic [NW-1:0]    r_u, r_f, r_s, r_fv;
    logic [LEN_W-1:0] r_len;
    logic [GW:0]      r_clr;
    logic             r_clr_done;

    // memories
    logic          g_we;
    logic [GW-1:0] g_waddr, g_raddr;
    logic [NW-1:0] g_wdata, g_rdata;
    logic          f_we;
    logic [NW-1:0] f_waddr, f_wdata, f_raddr, f_rdata;
    logic          m_we;
    logic [NW-1:0] m_waddr, m_raddr;
    logic [LEN_W-1:0] m_wdata, m_rdata;
    logic          q_we;
    logic [NW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
    logic          s_we;
    logic [SW-1:0] s_waddr, s_raddr;
    logic [SYM_W+NW-1:0] s_wdata, s_rdata;

    function automatic logic [GW-1:0] gaddr(input logic [NW-1:0] n, input logic [AW-1:0] c);
        logic [GW+NW-1:0] p;
        p = (GW+NW)'(n) * (GW+NW)'(ALPHABET) + (GW+NW)'(c);
        return p[GW-1:0];
    endfunction

    mpce_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata));
    mpce_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));
    mpce_ram #(.WIDTH(LEN_W), .DEPTH(NODE_COUNT)) u_mlen (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata));
    mpce_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));
    mpce_ram #(.WIDTH(SYM_W+NW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));

    // the pop runs after the push, so r_sp already counts the new letter
    logic [SPW-1:0] sp_inc, sp_after;
    logic [LEN_W-1:0] len_clip;
    assign sp_inc = r_sp + SPW'(1);
    always_comb begin
        if (r_len > LEN_W'(r_sp)) len_clip = LEN_W'(r_sp);
        else len_clip = r_len;
        sp_after = r_sp - SPW'(len_clip);
    end

    // memory port steering
    always_comb begin
        g_we = 1'b0; g_waddr = gaddr(r_cursor, r_sym[AW-1:0]); g_wdata = '0;
        g_raddr = gaddr(r_cursor, r_sym[AW-1:0]);
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = r_u;
        m_we = 1'b0; m_waddr = r_cursor; m_wdata = r_ins_depth; m_raddr = r_s;
        q_we = 1'b0; q_waddr = r_tail[NW-1:0]; q_wdata = '0; q_raddr = r_head[NW-1:0];
        s_we = 1'b0; s_waddr = r_sp[SW-1:0]; s_wdata = {r_sym, r_s};
        // text letters keep the top entry addressed while a pop waits on the read
        s_raddr = (r_cmd == CMD_TEXT) ? r_sp[SW-1:0] - SW'(1) : r_idx[SW-1:0];
        if (!r_clr_done) begin
            g_we = 1'b1; g_waddr = r_clr[GW-1:0];
            m_we = !r_clr[GW] && (r_clr[GW-1:0] < GW'(NODE_COUNT));
            m_waddr = r_clr[NW-1:0]; m_wdata = '0;
        end else begin
            case (i_op)
                OP_INS_DO: begin
                    g_we = (g_rdata == '0);
                    g_wdata = r_node_count[NW-1:0];
                end
                OP_END_DO: m_we = (r_cursor != '0);
                OP_TXT_RD: g_raddr = gaddr(r_mstate, r_sym[AW-1:0]);
                OP_TXT_DO: s_we = 1'b1;
                OP_TXT_POP: s_raddr = sp_after[SW-1:0] - SW'(1);
                OP_B_ROOTRD: g_raddr = gaddr('0, r_c);
                OP_B_ROOTDO: begin
                    if (g_rdata != '0 && r_tail < NCW'(NODE_COUNT)) begin
                        f_we = 1'b1; f_waddr = g_rdata; f_wdata = '0;
                        q_we = 1'b1; q_wdata = g_rdata;
                    end
                end
                OP_B_FAILRD: f_raddr = q_rdata;
                // fail node's edge first, then the node's own edge for the same letter
                OP_B_CRD: g_raddr = gaddr(r_f, r_c);
                OP_B_CWAIT: g_raddr = gaddr(r_u, r_c);
                OP_B_CDO: begin
                    if (g_rdata != '0) begin
                        f_we = 1'b1; f_waddr = g_rdata; f_wdata = r_fv;
                        q_we = r_tail < NCW'(NODE_COUNT); q_wdata = g_rdata;
                    end else begin
                        g_we = 1'b1; g_waddr = gaddr(r_u, r_c); g_wdata = r_fv;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_built <= 1'b0; r_node_count <= NCW'(1); r_cursor <= '0;
            r_ins_depth <= '0; r_sp <= '0; r_mstate <= '0;
            r_clr <= '0; r_clr_done <= 1'b0;
        end else begin
            if (!r_clr_done) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr[GW-1:0] == GW'(GD - 1)) r_clr_done <= 1'b1;
            end
            case (i_op)
                OP_LATCH: begin
                    r_cmd <= i_item.command; r_sym <= i_item.symbol;
                    r_idx <= i_item.read_index;
                    r_status <= ST_OK; r_removed <= '0; r_rsym <= '0;
                end
                OP_SET_BAD:      r_status <= ST_BAD;
                OP_SET_NODEFULL: r_status <= ST_NODEFULL;
                OP_SET_STKFULL:  r_status <= ST_STKFULL;
                OP_INS_DO: begin
                    if (g_rdata == '0) begin
                        r_cursor <= r_node_count[NW-1:0];
                        r_node_count <= r_node_count + NCW'(1);
                    end else begin
                        r_cursor <= g_rdata;
                    end
                    if (r_ins_depth < DEPTH_MAX) r_ins_depth <= r_ins_depth + 1'b1;
                end
                OP_END_DO: begin r_cursor <= '0; r_ins_depth <= '0; end
                OP_TXT_LEN: r_s <= g_rdata;
                OP_TXT_DO: begin
                    r_len <= m_rdata;
                    r_sp <= sp_inc;
                    if (m_rdata == '0) r_mstate <= r_s;
                end
                OP_TXT_POP: begin
                    r_removed <= len_clip;
                    r_sp <= sp_after;
                    if (sp_after == '0) r_mstate <= '0;
                end
                OP_TXT_POPDO: r_mstate <= s_rdata[NW-1:0];
                OP_RD_DO:  r_rsym <= s_rdata[SYM_W+NW-1:NW];
                OP_CLEAR:  begin r_sp <= '0; r_mstate <= '0; end
                OP_B_INIT: begin r_head <= '0; r_tail <= '0; r_c <= '0; end
                OP_B_ROOTDO: begin
                    if (g_rdata != '0 && r_tail < NCW'(NODE_COUNT)) r_tail <= r_tail + 1'b1;
                    r_c <= (r_c == AW'(ALPHABET - 1)) ? '0 : r_c + 1'b1;
                end
                OP_B_DEQ: r_head <= r_head + 1'b1;
                OP_B_FAILRD: r_u <= q_rdata;
                OP_B_FAIL: r_f <= f_rdata;
                OP_B_CWAIT: r_fv <= g_rdata;
                OP_B_CDO: begin
                    if (g_rdata != '0 && r_tail < NCW'(NODE_COUNT)) r_tail <= r_tail + 1'b1;
                    r_c <= (r_c == AW'(ALPHABET - 1)) ? '0 : r_c + 1'b1;
                end
                OP_B_DONE: r_built <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_clr_done = r_clr_done;
    always_comb begin
        o_st.cmd        = r_cmd;
        o_st.built      = r_built;
        o_st.sym_ok     = r_sym < SYM_W'(ALPHABET);
        o_st.stk_full   = r_sp >= SPW'(STACK_DEPTH);
        o_st.node_full  = r_node_count >= NCW'(NODE_COUNT);
        o_st.child_zero = g_rdata == '0;
        o_st.len_zero   = m_rdata == '0;
        o_st.sp_zero    = sp_after == '0;
        o_st.idx_ok     = (IDX_W+SPW)'(r_idx) < (IDX_W+SPW)'(r_sp);
        o_st.queue_empty = r_head >= r_tail;
        o_st.last_sym   = r_c == AW'(ALPHABET - 1);
        o_item.status         = r_status;
        o_item.stack_depth    = LEN_W'(r_sp);
        o_item.removed_length = r_removed;
        o_item.read_symbol    = r_rsym;
    end

`include "multi_pattern_censor_engine_core_macros.svh"
    `MPCE_ASSERT_IMPL(a_sp_bound, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH))
    `MPCE_ASSERT_IMPL(a_nodes_bound, i_clk, i_rst_n,
        (r_node_count <= NCW'(NODE_COUNT)) && (r_node_count != '0))
    `MPCE_ASSERT_IMPL(a_built_sticks, i_clk, i_rst_n, r_built |=> r_built)
endmodule
`default_nettype wire

### sv/multi_pattern_censor_engine_core.sv
`default_nettype none
// Aho-Corasick censor engine. Patterns are entered letter by letter into a
// trie, a build command computes the full goto table and failure links by a
// breadth-first walk, and text letters are then pushed on a stack; a completed
// pattern pops its letters. One item is worked at a time: after reset a
// clearing pass zeroes the goto table and the match-length table before any
// item is accepted. A text letter does a goto read, a match-length read and a
// stack write; a match then pops its letters, and when letters are left the
// new state is read back from the stack. A build visits every letter of the
// root and then of each queued trie node, reading the fail node's edge and the
// node's own edge for each letter. A stalled result is held, and the next item
// is accepted the cycle after the result goes.
module multi_pattern_censor_engine_core #(
    parameter int unsigned NODE_COUNT  = 1024,
    parameter int unsigned ALPHABET    = 26,
    parameter int unsigned STACK_DEPTH = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mpce_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mpce_pkg::t_out_item      o_out_item
);
    import mpce_pkg::*;

    t_op         op;
    t_status_bus st;
    logic        clr_done;

    mpce_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_clr_done(clr_done), .i_st(st), .o_op(op));

    mpce_datapath #(
        .NODE_COUNT(NODE_COUNT), .ALPHABET(ALPHABET), .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_item), .i_op(op),
        .o_st(st), .o_clr_done(clr_done), .o_item(o_out_item));
endmodule
`default_nettype wire
